@@ rtl/b64e_pkg.sv @@
package b64e_pkg;

    localparam int B64E_QUEUE_DEPTH = 2;

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_PLUS    = 7'h2B;
    localparam logic [6:0] ASCII_SLASH   = 7'h2F;
    localparam logic [6:0] ASCII_PAD     = 7'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out_item;

    // One classified input byte: up to two sextets, then zero to two pad characters.
    typedef struct packed {
        logic [5:0] sextet0;
        logic [5:0] sextet1;
        logic       two_data;
        logic [1:0] pad_cnt;
        logic       last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Map a six-bit value onto the standard base64 alphabet.
    function automatic logic [6:0] b64_char(input logic [5:0] idx);
        logic [6:0] v;
        v = {1'b0, idx};
        if (idx < 6'd26) begin
            b64_char = ASCII_UPPER_A + v;
        end else if (idx < 6'd52) begin
            b64_char = ASCII_LOWER_A + (v - 7'd26);
        end else if (idx < 6'd62) begin
            b64_char = ASCII_ZERO + (v - 7'd52);
        end else if (idx == 6'd62) begin
            b64_char = ASCII_PLUS;
        end else begin
            b64_char = ASCII_SLASH;
        end
    endfunction

endpackage

@@ rtl/b64e_front.sv @@
module b64e_front
    import b64e_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [7:0] b;
    logic       accept;

    assign b       = i_data.data_byte;
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        o_job   = '0;
        n_phase = r_phase;
        n_carry = r_carry;
        unique case (r_phase)
            PH_1: begin
                o_job.sextet0 = {r_carry[1:0], b[7:4]};
                o_job.sextet1 = {b[3:0], 2'b00};
                if (i_data.last_byte) begin
                    o_job.two_data = 1'b1;
                    o_job.pad_cnt  = 2'd1;
                    o_job.last     = 1'b1;
                    n_phase        = PH_0;
                    n_carry        = '0;
                end else begin
                    n_phase = PH_2;
                    n_carry = b[3:0];
                end
            end
            PH_2: begin
                o_job.sextet0  = {r_carry, b[7:6]};
                o_job.sextet1  = b[5:0];
                o_job.two_data = 1'b1;
                o_job.last     = i_data.last_byte;
                n_phase        = PH_0;
                n_carry        = '0;
            end
            default: begin
                o_job.sextet0 = b[7:2];
                o_job.sextet1 = {b[1:0], 4'b0000};
                if (i_data.last_byte) begin
                    o_job.two_data = 1'b1;
                    o_job.pad_cnt  = 2'd2;
                    o_job.last     = 1'b1;
                    n_phase        = PH_0;
                    n_carry        = '0;
                end else begin
                    n_phase = PH_1;
                    n_carry = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_carry <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

@@ rtl/b64e_queue.sv @@
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = B64E_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/b64e_back.sv @@
module b64e_back
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out_item  r_data;
    logic       load;
    logic       job_end;
    logic [1:0] last_idx;
    logic [6:0] sel_char;

    assign last_idx = {1'b0, i_head.two_data} + i_head.pad_cnt;
    assign job_end  = (r_idx == last_idx);
    assign load     = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_pop    = load && job_end;

    always_comb begin
        if (r_idx == 2'd0) begin
            sel_char = b64_char(i_head.sextet0);
        end else if (r_idx == 2'd1 && i_head.two_data) begin
            sel_char = b64_char(i_head.sextet1);
        end else begin
            sel_char = ASCII_PAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= job_end ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.out_char  <= sel_char;
            r_data.last_char <= i_head.last && job_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/base64_stream_encoder.sv @@
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_ready  | i_data : t_in_item  (data_byte, last_byte)
// output  | out       | o_valid / i_ready  | o_data : t_out_item (out_char, last_char)
//
// An input transaction is taken whenever the job queue has room.
// Output leaves at one character per cycle from a registered stage while i_ready
// is high and a job is queued, so one byte yields one to four output characters
// (one or two mid-group, two to four on a last byte, depending on where it falls
// in its group); the output register sets the sustained rate.
// Reset is synchronous and active low; it returns to the start of a group.
// Output stalls fill the queue and then hold o_ready low; input gaps drain it.
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = B64E_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    // The front tracks the position in the three-byte group and the carried
    // low bits, and turns each byte into a job: the sextets it completes and
    // the amount of padding it owes.
    t_job    front_job;
    logic    front_push;
    t_job    q_head;
    t_q_stat q_stat;
    logic    back_pop;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_stat.full),
        .o_push   (front_push),
        .o_job    (front_job)
    );

    // A short queue lets the front keep taking bytes while the back is still
    // sending the characters of earlier ones.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (back_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // The back walks the head job one character per cycle while i_ready allows, mapping
    // sextets through the alphabet and appending '=' where the job asks for it.
    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (back_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    // Padding is only ever owed at the end of a message.
    a_pad_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push && !front_job.last |-> front_job.pad_cnt == 2'd0)
        else $error("padding requested for a byte that is not last");

    // A full queue can never also report empty.
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !q_stat.empty)
        else $error("queue reports full and empty together");

    // A new output transaction appears only when a job was waiting.
    a_out_from_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!q_stat.empty))
        else $error("output became valid with no queued job");

    // The queue is never pushed while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> !q_stat.full)
        else $error("push into a full queue");

endmodule
